// File: rtl/core/cmtm_pkg.sv
// Shared types and constants of the confusion-matrix track matcher.
package cmtm_pkg;

  localparam int FRAC_W = 16;          // Q0.16 fraction bits
  localparam int QW     = FRAC_W + 1;  // fraction range 0..1.0 inclusive

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_AXIAL_ONLY     = 2'd0;
  localparam reg_index_t REG_MIN_PURITY     = 2'd1;
  localparam reg_index_t REG_MIN_EFFICIENCY = 2'd2;
  localparam reg_index_t REG_RELATE         = 2'd3;

  typedef enum logic [2:0] {
    CLS_GHOST       = 3'd0,
    CLS_BACKGROUND  = 3'd1,
    CLS_CLONE       = 3'd2,
    CLS_FOUND_MATCH = 3'd3,
    CLS_MISSING     = 3'd4,
    CLS_MERGED      = 3'd5,
    CLS_TRUE_MATCH  = 3'd6
  } match_class_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quot;
  } div_result_t;

endpackage

// File: rtl/core/confusion_matrix_track_matcher_core.sv
// Top level of the confusion-matrix track matcher: sequencer and datapath.
//
// Usage: requests enter on item_valid/item_ready; item_ready is high only
// while the block is idle. A load request (operation 0) adds one hit to the
// confusion matrix: one read-modify-write per found-track row plus the totals
// row, pipelined one row a cycle. Skipped hits (stereo in axial-only mode,
// true track out of range) leave the matrix untouched.
// A finish request (operation 1) scans the matrix through the single RAM read
// port and runs the shared 16-step divider once per track. Results go out on
// result_valid/result_ready: nf found-track classes, then nt true-track
// classes, the final one flagged by last. A stalled receiver simply holds
// the sequencer in its output state; nothing is lost.
// After the last result (or at once for an empty event) the matrix is swept
// to zero, one word a cycle. The same sweep runs after reset, during which
// no request is taken. Configuration writes are taken at any time.
module confusion_matrix_track_matcher_core #(
  parameter int MAX_FOUND_TRACKS = 32,
  parameter int MAX_TRUE_TRACKS  = 32,
  parameter int COUNT_WIDTH      = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_wen,
  input  cmtm_pkg::reg_index_t         cfg_index,
  input  logic [16:0]                  cfg_data,
  // request channel
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         operation,
  input  logic [4:0]                   true_track,
  input  logic                         hit_is_background,
  input  logic                         hit_is_stereo,
  input  logic [31:0]                  found_track_mask,
  input  logic [5:0]                   true_track_count,
  input  logic [5:0]                   found_track_count,
  // result channel
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         track_kind,
  output logic [4:0]                   track_index,
  output logic [2:0]                   match_class,
  output logic [5:0]                   partner_index,
  output logic                         relation_made,
  output logic signed [17:0]           weight,
  output logic                         last
);
  import cmtm_pkg::*;

  // Matrix rows: found tracks plus one row holding per-column hit totals.
  localparam int ROWS  = MAX_FOUND_TRACKS + 1;
  localparam int RW    = $clog2(ROWS);
  localparam int COLS  = MAX_TRUE_TRACKS + 1;     // last column = background
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int PW    = (RW > CW) ? RW : CW;
  localparam int SUM_W = COUNT_WIDTH + CW;
  localparam int PUR_W = 1 + QW + CW;
  localparam int EFF_W = 1 + QW + RW;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [CW-1:0] BKG_COL  = CW'(MAX_TRUE_TRACKS);
  localparam logic [RW-1:0] TOT_ROW  = RW'(MAX_FOUND_TRACKS);

  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_HIT      = 16'h0004,
    S_PSCAN    = 16'h0008,
    S_PGO      = 16'h0010,
    S_PDIV     = 16'h0020,
    S_ESCAN    = 16'h0040,
    S_EGO      = 16'h0080,
    S_EDIV     = 16'h0100,
    S_EF_RD    = 16'h0200,
    S_EF_LATCH = 16'h0400,
    S_EF_FORM  = 16'h0800,
    S_ET_RD    = 16'h1000,
    S_ET_LATCH = 16'h2000,
    S_ET_FORM  = 16'h4000,
    S_OUT      = 16'h8000
  } state_t;

  state_t state;

  // config registers
  logic        axial_only;
  logic [16:0] min_purity;
  logic [16:0] min_efficiency;
  logic        relate_clones_merged;

  // sequencer registers
  logic [PW-1:0]          cnt;
  logic                   issuing;
  logic                   rd_valid;
  logic                   rd_last;
  logic [PW-1:0]          rd_pos;
  logic [RW-1:0]          row;
  logic [CW-1:0]          col_t;
  logic [RW-1:0]          nf;
  logic [CW-1:0]          nt;
  logic [CW-1:0]          hit_col;
  logic [ROWS-1:0]        hit_mask;
  logic [AW-1:0]          clr;

  // scan accumulators
  logic [COUNT_WIDTH-1:0] best;
  logic [SUM_W-1:0]       sum;
  logic [PW-1:0]          arg;

  // emit latches
  logic [PW-1:0]          lat_arg;
  logic [QW-1:0]          lat_val;
  logic                   lat_ok;

  // RAM ports
  logic                   cm_we;
  logic [AW-1:0]          cm_waddr, cm_raddr;
  logic [COUNT_WIDTH-1:0] cm_wdata, cm_rdata;
  logic                   pur_we;
  logic [RW-1:0]          pur_raddr;
  logic [PUR_W-1:0]       pur_wdata, pur_rdata;
  logic                   eff_we;
  logic [CW-1:0]          eff_raddr;
  logic [EFF_W-1:0]       eff_wdata, eff_rdata;

  // divider
  div_result_t            div_res;
  logic                   div_start;
  logic                   div_ok;

  // misc combinational
  logic [ROWS-1:0]        mask_ext;
  logic [CW-1:0]          colsel_p, colsel_rd;
  logic [RW-1:0]          rowsel_e;
  logic [PW-1:0]          limit;
  logic                   scanning;
  logic                   issue_last;
  logic                   hit_drop;
  logic [CW-1:0]          nt_in;
  logic [RW-1:0]          nf_in;
  logic [CW-1:0]          p_col;
  logic [RW-1:0]          b_row;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = (state == S_OUT);

  // mask bits above 31 or at MAX_FOUND_TRACKS and up are ignored; totals row always set
  for (genvar i = 0; i < ROWS; i++) begin : g_mask
    if (i == MAX_FOUND_TRACKS) begin : g_tot
      assign mask_ext[i] = 1'b1;
    end else if (i < 32) begin : g_bit
      assign mask_ext[i] = found_track_mask[i];
    end else begin : g_none
      assign mask_ext[i] = 1'b0;
    end
  end

  always_comb begin
    hit_drop = (axial_only && hit_is_stereo) ||
               (!hit_is_background && ({2'b00, true_track} >= 7'(MAX_TRUE_TRACKS)));
    nt_in = ({1'b0, true_track_count} > 7'(MAX_TRUE_TRACKS)) ?
            CW'(MAX_TRUE_TRACKS) : CW'(true_track_count);
    nf_in = ({1'b0, found_track_count} > 7'(MAX_FOUND_TRACKS)) ?
            RW'(MAX_FOUND_TRACKS) : RW'(found_track_count);

    colsel_p  = (cnt[CW-1:0] == nt) ? BKG_COL : cnt[CW-1:0];
    colsel_rd = (rd_pos[CW-1:0] == nt) ? BKG_COL : rd_pos[CW-1:0];
    rowsel_e  = (cnt[RW-1:0] == nf) ? TOT_ROW : cnt[RW-1:0];

    scanning = 1'b0;
    limit    = '0;
    cm_raddr = '0;
    unique case (state)
      S_HIT: begin
        scanning = 1'b1;
        limit    = PW'(MAX_FOUND_TRACKS);
        cm_raddr = {cnt[RW-1:0], hit_col};
      end
      S_PSCAN: begin
        scanning = 1'b1;
        limit    = PW'(nt);
        cm_raddr = {row, colsel_p};
      end
      S_ESCAN: begin
        scanning = 1'b1;
        limit    = PW'(nf);
        cm_raddr = {rowsel_e, col_t};
      end
      default: ;
    endcase
    issue_last = issuing && (cnt == limit);

    // matrix writes: clearing sweep or saturating hit increment
    cm_we    = 1'b0;
    cm_waddr = {rd_pos[RW-1:0], hit_col};
    cm_wdata = (cm_rdata == CNT_MAX) ? cm_rdata : cm_rdata + COUNT_WIDTH'(1);
    if (state == S_CLEAR) begin
      cm_we    = 1'b1;
      cm_waddr = clr;
      cm_wdata = '0;
    end else if (state == S_HIT && rd_valid && hit_mask[rd_pos[RW-1:0]]) begin
      cm_we = 1'b1;
    end

    div_start = (state == S_PGO) || (state == S_EGO);
    div_ok    = (sum != '0) &&
                (div_res.quot >= ((state == S_PDIV) ? min_purity : min_efficiency));

    pur_we    = (state == S_PDIV) && div_res.done;
    pur_wdata = {div_ok, div_res.quot, arg[CW-1:0]};
    eff_we    = (state == S_EDIV) && div_res.done;
    eff_wdata = {div_ok, div_res.quot, arg[RW-1:0]};

    // second lookup of each emit step follows the partner read from the first
    pur_raddr = (state == S_ET_LATCH) ? eff_rdata[RW-1:0] : row;
    eff_raddr = (state == S_EF_LATCH) ? pur_rdata[CW-1:0] : col_t;

    p_col = lat_arg[CW-1:0];
    b_row = lat_arg[RW-1:0];
  end

  cmtm_ram #(.DATA_W(COUNT_WIDTH), .DEPTH(1 << AW)) u_matrix (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata)
  );

  cmtm_ram #(.DATA_W(PUR_W), .DEPTH(1 << RW)) u_purity (
    .clk(clk), .we(pur_we), .waddr(row), .wdata(pur_wdata),
    .raddr(pur_raddr), .rdata(pur_rdata)
  );

  cmtm_ram #(.DATA_W(EFF_W), .DEPTH(1 << CW)) u_effic (
    .clk(clk), .we(eff_we), .waddr(col_t), .wdata(eff_wdata),
    .raddr(eff_raddr), .rdata(eff_rdata)
  );

  cmtm_div #(.NUM_W(SUM_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(SUM_W'(best)), .den(sum), .result(div_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      axial_only           <= 1'b0;
      min_purity           <= 17'd6554;
      min_efficiency       <= 17'd6554;
      relate_clones_merged <= 1'b1;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_AXIAL_ONLY:     axial_only           <= cfg_data[0];
        REG_MIN_PURITY:     min_purity           <= cfg_data;
        REG_MIN_EFFICIENCY: min_efficiency       <= cfg_data;
        REG_RELATE:         relate_clones_merged <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      // read issue shared by all scans, one word a cycle
      if (scanning && issuing) begin
        rd_valid <= 1'b1;
        rd_pos   <= cnt;
        rd_last  <= issue_last;
        if (issue_last) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + PW'(1);
        end
      end else begin
        rd_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item_valid) begin
            cnt <= '0;
            if (operation == OP_LOAD) begin
              hit_col  <= hit_is_background ? BKG_COL : CW'(true_track);
              hit_mask <= mask_ext;
              if (!hit_drop) begin
                issuing <= 1'b1;
                state   <= S_HIT;
              end
            end else begin
              nt  <= nt_in;
              nf  <= nf_in;
              row <= '0;
              if (nt_in == '0 || nf_in == '0) begin
                clr   <= '0;
                state <= S_CLEAR;
              end else begin
                issuing <= 1'b1;
                state   <= S_PSCAN;
              end
            end
          end
        end

        S_HIT: begin
          if (rd_valid && rd_last) begin
            state <= S_IDLE;
          end
        end

        S_PSCAN: begin
          if (rd_valid) begin
            sum <= (rd_pos == '0) ? SUM_W'(cm_rdata) : sum + SUM_W'(cm_rdata);
            if (rd_pos == '0 || cm_rdata > best) begin
              best <= cm_rdata;
              arg  <= PW'(colsel_rd);
            end
            if (rd_last) begin
              state <= S_PGO;
            end
          end
        end

        S_PGO: state <= S_PDIV;

        S_PDIV: begin
          if (div_res.done) begin
            cnt     <= '0;
            issuing <= 1'b1;
            if (row == nf - RW'(1)) begin
              col_t <= '0;
              state <= S_ESCAN;
            end else begin
              row   <= row + RW'(1);
              state <= S_PSCAN;
            end
          end
        end

        S_ESCAN: begin
          if (rd_valid) begin
            if (rd_last) begin
              sum   <= SUM_W'(cm_rdata);    // true-track total
              state <= S_EGO;
            end else if (rd_pos == '0 || cm_rdata > best) begin
              best <= cm_rdata;
              arg  <= rd_pos;
            end
          end
        end

        S_EGO: state <= S_EDIV;

        S_EDIV: begin
          if (div_res.done) begin
            if (col_t == nt - CW'(1)) begin
              row   <= '0;
              state <= S_EF_RD;
            end else begin
              col_t   <= col_t + CW'(1);
              cnt     <= '0;
              issuing <= 1'b1;
              state   <= S_ESCAN;
            end
          end
        end

        S_EF_RD: state <= S_EF_LATCH;

        S_EF_LATCH: begin
          lat_ok  <= pur_rdata[PUR_W-1];
          lat_val <= pur_rdata[CW +: QW];
          lat_arg <= PW'(pur_rdata[CW-1:0]);
          state   <= S_EF_FORM;
        end

        S_EF_FORM: begin
          track_kind    <= 1'b0;
          track_index   <= 5'(row);
          partner_index <= 6'(p_col);
          last          <= 1'b0;
          match_class   <= CLS_GHOST;
          relation_made <= 1'b0;
          weight        <= '0;
          if (!lat_ok) begin
            match_class <= CLS_GHOST;
          end else if (p_col == BKG_COL) begin
            match_class <= CLS_BACKGROUND;
          end else if (eff_rdata[RW-1:0] != row) begin
            // another found track is the best one for this true track
            if (eff_rdata[EFF_W-1]) begin
              match_class   <= CLS_CLONE;
              relation_made <= relate_clones_merged;
              weight        <= -$signed({1'b0, lat_val});
            end
          end else begin
            match_class   <= CLS_FOUND_MATCH;
            relation_made <= 1'b1;
            weight        <= $signed({1'b0, lat_val});
          end
          state <= S_OUT;
        end

        S_ET_RD: state <= S_ET_LATCH;

        S_ET_LATCH: begin
          lat_ok  <= eff_rdata[EFF_W-1];
          lat_val <= eff_rdata[RW +: QW];
          lat_arg <= PW'(eff_rdata[RW-1:0]);
          state   <= S_ET_FORM;
        end

        S_ET_FORM: begin
          track_kind    <= 1'b1;
          track_index   <= 5'(col_t);
          partner_index <= 6'(b_row);
          last          <= (col_t == nt - CW'(1));
          match_class   <= CLS_MISSING;
          relation_made <= 1'b0;
          weight        <= '0;
          if (lat_ok) begin
            if (pur_rdata[CW-1:0] != col_t) begin
              match_class   <= CLS_MERGED;
              relation_made <= relate_clones_merged;
              weight        <= -$signed({1'b0, lat_val});
            end else begin
              match_class   <= CLS_TRUE_MATCH;
              relation_made <= 1'b1;
              weight        <= $signed({1'b0, lat_val});
            end
          end
          state <= S_OUT;
        end

        S_OUT: begin
          if (result_ready) begin
            if (last) begin
              clr   <= '0;
              state <= S_CLEAR;
            end else if (!track_kind) begin
              if (row == nf - RW'(1)) begin
                col_t <= '0;
                state <= S_ET_RD;
              end else begin
                row   <= row + RW'(1);
                state <= S_EF_RD;
              end
            end else begin
              col_t <= col_t + CW'(1);
              state <= S_ET_RD;
            end
          end
        end

        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

// File: rtl/core/cmtm_ram.sv
// Generic simple dual-port RAM with registered read.
module cmtm_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cmtm_div.sv
// Shared radix-2 restoring divider giving floor(num * 2^16 / den), capped at 2^16 (1.0) when num >= den, 0 if den is 0.
module cmtm_div #(
  parameter int NUM_W = 22
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NUM_W-1:0]         num,
  input  logic [NUM_W-1:0]         den,
  output cmtm_pkg::div_result_t    result
);
  import cmtm_pkg::*;

  localparam int SW = $clog2(FRAC_W);

  logic              busy;
  logic              done;
  logic [SW-1:0]     step;
  logic [NUM_W:0]    rem;
  logic [QW-1:0]     quot;
  logic [NUM_W:0]    shifted;
  logic              fits;

  // rem < den holds while iterating, so the shifted remainder fits NUM_W+1 bits
  always_comb begin
    shifted = {rem[NUM_W-1:0], 1'b0};
    fits    = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (den == '0) begin
          quot <= '0;
          done <= 1'b1;
        end else if (num >= den) begin
          quot <= QW'(1) << FRAC_W;
          done <= 1'b1;
        end else begin
          rem  <= {1'b0, num};
          quot <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= fits ? (shifted - {1'b0, den}) : shifted;
        quot <= {quot[QW-2:0], fits};
        step <= step + SW'(1);
        if (step == SW'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result.done = done;
  assign result.quot = quot;

endmodule
